### rtl/core/lgat_pkg.sv
// Shared constants, opcodes and controller/datapath interface types for the
// line group address table. No dependencies.
package lgat_pkg;

    localparam int ENTRIES     = 16;
    localparam int ADDR_BYTES  = 6;
    localparam int PHASES      = 3;
    localparam int ADDR_W      = 48;
    localparam int LINE_W      = 8;
    localparam int OP_W        = 2;
    localparam int PHASE_W     = 2;
    localparam int INDEX_OUT_W = 4;
    localparam int COUNT_OUT_W = 5;

    localparam int ENTRY_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int CMP_W   = (8 * ADDR_BYTES < ADDR_W) ? 8 * ADDR_BYTES : ADDR_W;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    localparam logic [PHASE_W-1:0] PHASE_A = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_B = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_C = 2'd2;

    typedef struct packed {
        logic load;
        logic issue;
        logic eval;
        logic commit;
    } lgat_cmd_t;

    typedef struct packed {
        logic hit;
        logic last;
    } lgat_status_t;

endpackage

### rtl/core/lgat_dp.sv
// Datapath of the line group address table: entry line registers, address
// memory, scan pipeline and result registers. Depends on lgat_pkg.
module lgat_dp
    import lgat_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  lgat_cmd_t              cmd,
    output lgat_status_t           status,
    input  logic [OP_W-1:0]        op,
    input  logic [ADDR_W-1:0]      key_addr,
    input  logic [LINE_W-1:0]      line_number,
    input  logic [ADDR_W-1:0]      phase_a_addr,
    input  logic [ADDR_W-1:0]      phase_b_addr,
    input  logic [ADDR_W-1:0]      phase_c_addr,
    output logic                   done,
    output logic                   success,
    output logic                   found,
    output logic [INDEX_OUT_W-1:0] entry_index,
    output logic [LINE_W-1:0]      found_line,
    output logic [PHASE_W-1:0]     phase,
    output logic [COUNT_OUT_W-1:0] valid_count
);

    typedef logic [PHASES-1:0][CMP_W-1:0] addr_row_t;

    op_t                    op_reg;
    logic [CMP_W-1:0]       key_reg;
    logic [LINE_W-1:0]      line_reg;
    addr_row_t              row_in_reg;
    logic [ENTRY_W-1:0]     scan_reg;
    logic                   st_valid_reg;
    logic [ENTRY_W-1:0]     st_idx_reg;
    logic [LINE_W-1:0]      st_line_reg;
    addr_row_t              st_row_reg;
    logic                   free_found_reg;
    logic [ENTRY_W-1:0]     free_idx_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [LINE_W-1:0]      entry_line_reg [ENTRIES];
    addr_row_t              mem [ENTRIES];

    logic                   done_reg;
    logic                   success_reg;
    logic                   found_reg;
    logic [INDEX_OUT_W-1:0] index_reg;
    logic [LINE_W-1:0]      fline_reg;
    logic [PHASE_W-1:0]     phase_reg;

    logic [PHASES-1:0]      match_vec;
    logic [PHASE_W-1:0]     match_phase;
    logic                   lookup_hit;
    logic                   line_hit;
    logic                   cond;
    logic                   take_free;
    logic                   ins_write;
    logic                   del_clear;
    logic [CNT_W-1:0]       count_next;
    logic                   success_next;
    logic                   found_next;
    logic [INDEX_OUT_W-1:0] index_next;
    logic [LINE_W-1:0]      fline_next;
    logic [PHASE_W-1:0]     phase_next;

    always_comb
    begin
        for (int p = 0; p < PHASES; p++)
        begin
            match_vec[p] = (st_row_reg[p] == key_reg);
        end
    end

    always_comb
    begin
        priority if (match_vec[0])
        begin
            match_phase = PHASE_A;
        end
        else if (match_vec[1])
        begin
            match_phase = PHASE_B;
        end
        else
        begin
            match_phase = PHASE_C;
        end
    end

    assign lookup_hit = (st_line_reg != '0) && (|match_vec);
    assign line_hit   = (st_line_reg == line_reg);

    always_comb
    begin
        unique case (op_reg)
            OP_LOOKUP: cond = lookup_hit;
            OP_INSERT: cond = line_hit;
            OP_DELETE: cond = line_hit && (line_reg != '0);
            OP_NOP:    cond = 1'b0;
        endcase
    end

    assign status.hit  = st_valid_reg && cond;
    assign status.last = st_valid_reg && (st_idx_reg == ENTRY_W'(ENTRIES - 1));

    assign take_free = cmd.eval && st_valid_reg && (st_line_reg == '0) && !free_found_reg;

    always_comb
    begin
        count_next   = count_reg;
        success_next = 1'b0;
        found_next   = 1'b0;
        index_next   = '0;
        fline_next   = '0;
        phase_next   = '0;
        ins_write    = 1'b0;
        del_clear    = 1'b0;
        unique case (op_reg)
            OP_LOOKUP:
            begin
                if (status.hit)
                begin
                    success_next = 1'b1;
                    found_next   = 1'b1;
                    index_next   = INDEX_OUT_W'(st_idx_reg);
                    fline_next   = st_line_reg;
                    phase_next   = match_phase;
                end
            end
            OP_INSERT:
            begin
                ins_write    = !status.hit && free_found_reg;
                success_next = ins_write;
                if (ins_write)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_DELETE:
            begin
                del_clear    = status.hit;
                success_next = status.hit || (line_reg == '0);
                if (del_clear)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_NOP:
            begin
                success_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg       <= '0;
            st_valid_reg   <= 1'b0;
            free_found_reg <= 1'b0;
            count_reg      <= '0;
            done_reg       <= 1'b0;
            success_reg    <= 1'b0;
            found_reg      <= 1'b0;
            index_reg      <= '0;
            fline_reg      <= '0;
            phase_reg      <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                entry_line_reg[i] <= '0;
            end
        end
        else
        begin
            done_reg <= cmd.commit;
            if (cmd.load)
            begin
                scan_reg       <= '0;
                st_valid_reg   <= 1'b0;
                free_found_reg <= 1'b0;
            end
            if (cmd.issue)
            begin
                st_valid_reg <= 1'b1;
                scan_reg     <= scan_reg + ENTRY_W'(1);
            end
            if (take_free)
            begin
                free_found_reg <= 1'b1;
            end
            if (cmd.commit)
            begin
                count_reg   <= count_next;
                success_reg <= success_next;
                found_reg   <= found_next;
                index_reg   <= index_next;
                fline_reg   <= fline_next;
                phase_reg   <= phase_next;
                if (ins_write)
                begin
                    entry_line_reg[free_idx_reg] <= line_reg;
                end
                if (del_clear)
                begin
                    entry_line_reg[st_idx_reg] <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg        <= op_t'(op);
            key_reg       <= key_addr[CMP_W-1:0];
            line_reg      <= line_number;
            row_in_reg[0] <= phase_a_addr[CMP_W-1:0];
            row_in_reg[1] <= phase_b_addr[CMP_W-1:0];
            row_in_reg[2] <= phase_c_addr[CMP_W-1:0];
        end
        if (cmd.issue)
        begin
            st_idx_reg  <= scan_reg;
            st_line_reg <= entry_line_reg[scan_reg];
            st_row_reg  <= mem[scan_reg];
        end
        if (take_free)
        begin
            free_idx_reg <= st_idx_reg;
        end
        if (cmd.commit && ins_write)
        begin
            mem[free_idx_reg] <= row_in_reg;
        end
    end

    assign done        = done_reg;
    assign success     = success_reg;
    assign found       = found_reg;
    assign entry_index = index_reg;
    assign found_line  = fline_reg;
    assign phase       = phase_reg;
    assign valid_count = COUNT_OUT_W'(count_reg);

endmodule

### rtl/core/lgat_ctrl.sv
// Controller state machine of the line group address table: sequences load,
// scan and commit of one transaction. Depends on lgat_pkg.
module lgat_ctrl
    import lgat_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  lgat_status_t status,
    output lgat_cmd_t    cmd,
    output logic         busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   stop;

    assign stop = status.hit || status.last;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.eval  = 1'b1;
                cmd.issue = !stop;
                if (stop)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

### rtl/core/line_group_address_table_core.sv
// Top level of the line group address table: joins the controller and the
// datapath. Depends on lgat_pkg, lgat_ctrl and lgat_dp.
//
// Channel   Handshake             Ports
// request   start && !busy        op, key_addr, line_number, phase_a/b/c_addr
// result    done (one cycle)      success, found, entry_index, found_line,
//                                 phase, valid_count
//
// A transaction scans the entries one per cycle through the address memory
// read port and stops at the first hit or after the last entry.
// Reset empties the table at once; the address memory needs no clearing.
// The done strobe is high for one cycle only and the receiver cannot stall it.
module line_group_address_table_core
    import lgat_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [OP_W-1:0]        op,
    input  logic [ADDR_W-1:0]      key_addr,
    input  logic [LINE_W-1:0]      line_number,
    input  logic [ADDR_W-1:0]      phase_a_addr,
    input  logic [ADDR_W-1:0]      phase_b_addr,
    input  logic [ADDR_W-1:0]      phase_c_addr,
    output logic                   done,
    output logic                   success,
    output logic                   found,
    output logic [INDEX_OUT_W-1:0] entry_index,
    output logic [LINE_W-1:0]      found_line,
    output logic [PHASE_W-1:0]     phase,
    output logic [COUNT_OUT_W-1:0] valid_count
);

    lgat_cmd_t    cmd;
    lgat_status_t status;

    lgat_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    lgat_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .op           (op),
        .key_addr     (key_addr),
        .line_number  (line_number),
        .phase_a_addr (phase_a_addr),
        .phase_b_addr (phase_b_addr),
        .phase_c_addr (phase_c_addr),
        .done         (done),
        .success      (success),
        .found        (found),
        .entry_index  (entry_index),
        .found_line   (found_line),
        .phase        (phase),
        .valid_count  (valid_count)
    );

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a transaction is still in progress");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe lasted more than one cycle");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_found_success: assert property (@(posedge clk) disable iff (!rst_n)
        (done && found) |-> success)
        else $error("lookup hit reported without success");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (entry_index == '0 && found_line == '0 && phase == '0))
        else $error("match fields nonzero without a lookup hit");

endmodule
